[rtl/lcdsp_pkg.sv]
// shared constants and types for the lcd shadow pixel write serializer
package lcdsp_pkg;

	localparam int X_W = 7;
	localparam int Y_W = 6;
	localparam int BYTE_W = 8;

	localparam int DISPLAY_ROWS = 64;
	localparam int BYTES_PER_ROW = 16;
	localparam int HALF_ROWS = 32;

	// shadow memory holds one column pair (even byte high, odd byte low) per word
	localparam int PAIRS_PER_ROW = (BYTES_PER_ROW + 1) / 2;
	localparam int RAM_DEPTH = DISPLAY_ROWS * PAIRS_PER_ROW;
	localparam int RAM_AW = $clog2(RAM_DEPTH);
	localparam int WORD_W = 2 * BYTE_W;

	localparam logic [BYTE_W-1:0] SYNC_CMD = 8'hF8;
	localparam logic [BYTE_W-1:0] SYNC_DATA = 8'hFA;
	localparam logic [BYTE_W-1:0] NIBBLE_HI = 8'hF0;
	localparam logic [BYTE_W-1:0] ROW_CMD_BASE = 8'h80;
	localparam logic [BYTE_W-1:0] COL_CMD_UPPER = 8'h80;
	localparam logic [BYTE_W-1:0] COL_CMD_LOWER = 8'h88;
	localparam logic [BYTE_W-1:0] PIXEL_MASK_MSB = 8'h80;

	typedef struct packed {
		logic [BYTE_W-1:0] row_cmd;
		logic [BYTE_W-1:0] col_cmd;
		logic [BYTE_W-1:0] even_byte;
		logic [BYTE_W-1:0] odd_byte;
	} ser_load_t;

endpackage

[rtl/lcdsp_if.sv]
// valid/ready channel interfaces for pixel writes and serial bytes
interface lcdsp_pix_if;
	logic       valid;
	logic       ready;
	logic [6:0] pixel_x;
	logic [5:0] pixel_y;
	logic       turn_on;

	modport source (output valid, pixel_x, pixel_y, turn_on, input ready);
	modport sink (input valid, pixel_x, pixel_y, turn_on, output ready);
endinterface

interface lcdsp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       frame_end;
	logic       last;

	modport source (output valid, out_byte, frame_end, last, input ready);
	modport sink (input valid, out_byte, frame_end, last, output ready);
endinterface

[rtl/lcdsp_ram.sv]
// generic simple dual port ram with registered read data
module lcdsp_ram #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 16,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/lcdsp_ser.sv]
// four-transfer, twelve-byte serializer with output holding registers
module lcdsp_ser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load_valid,
	input  lcdsp_pkg::ser_load_t load,
	output logic                free,
	lcdsp_byte_if.source        byte_out
);
	import lcdsp_pkg::*;

	localparam logic [1:0] PH_SYNC = 2'd0;
	localparam logic [1:0] PH_HIGH = 2'd1;
	localparam logic [1:0] PH_LOW  = 2'd2;
	localparam logic [1:0] XFER_ODD = 2'd3;

	logic       busy_q;
	logic [1:0] xfer_q;
	logic [1:0] phase_q;
	ser_load_t  data_q;

	logic              fire;
	logic              last_byte;
	logic [BYTE_W-1:0] val;

	assign last_byte = (xfer_q == XFER_ODD) && (phase_q == PH_LOW);
	assign fire = busy_q && byte_out.ready;
	assign free = !busy_q || (byte_out.ready && last_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			xfer_q  <= 2'd0;
			phase_q <= PH_SYNC;
		end else if (load_valid) begin
			busy_q  <= 1'b1;
			xfer_q  <= 2'd0;
			phase_q <= PH_SYNC;
		end else if (fire) begin
			if (last_byte) begin
				busy_q <= 1'b0;
			end else if (phase_q == PH_LOW) begin
				phase_q <= PH_SYNC;
				xfer_q  <= xfer_q + 2'd1;
			end else begin
				phase_q <= phase_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_valid) begin
			data_q <= load;
		end
	end

	always_comb begin
		case (xfer_q)
			2'd0:    val = data_q.row_cmd;
			2'd1:    val = data_q.col_cmd;
			2'd2:    val = data_q.even_byte;
			default: val = data_q.odd_byte;
		endcase
	end

	always_comb begin
		case (phase_q)
			PH_SYNC: byte_out.out_byte = xfer_q[1] ? SYNC_DATA : SYNC_CMD;
			PH_HIGH: byte_out.out_byte = val & NIBBLE_HI;
			PH_LOW:  byte_out.out_byte = {val[3:0], 4'b0000};
			default: byte_out.out_byte = '0;
		endcase
	end

	assign byte_out.valid = busy_q;
	assign byte_out.frame_end = (phase_q == PH_LOW);
	assign byte_out.last = last_byte;

endmodule

[rtl/lcd_shadow_pixel_write_serializer_unit.sv]
// top level: shadow image read-modify-write pipeline feeding the byte serializer
//
// channel     | dir | fields                        | transfer when
// ------------+-----+-------------------------------+--------------------------
// pixel_in    | in  | pixel_x, pixel_y, turn_on     | valid & ready
// byte_out    | out | out_byte, frame_end, last     | valid & ready
//
// each pixel write gives twelve byte transfers, one per cycle when the sink
// is ready; the byte serializer sets that figure
// pixel writes off the display are dropped and give no transfer
// a pixel enters s1 while the previous one is still being serialized; its
// shadow word is read as it moves to s2 and written back as it loads the
// serializer, with forwarding when back-to-back pixels hit the same word
// after reset a clearing pass zeroes all RAM_DEPTH (512) shadow words, one
// word per cycle, with pixel_in.ready low
// a stalled byte_out holds its byte; the pipeline stalls behind it
module lcd_shadow_pixel_write_serializer_unit (
	input  logic         clk,
	input  logic         arst_n,
	lcdsp_pix_if.sink    pixel_in,
	lcdsp_byte_if.source byte_out
);
	import lcdsp_pkg::*;

	// clearing pass
	logic              clr_busy_q;
	logic [RAM_AW-1:0] clr_addr_q;

	// stage 1: accepted pixel waiting to read its shadow word
	logic              valid_s1;
	logic [RAM_AW-1:0] addr_s1;
	logic [X_W-1:0]    x_s1;
	logic [Y_W-1:0]    y_s1;
	logic              on_s1;

	// stage 2: read data back, modify and write
	logic              valid_s2;
	logic [RAM_AW-1:0] addr_s2;
	logic [X_W-1:0]    x_s2;
	logic [Y_W-1:0]    y_s2;
	logic              on_s2;
	logic              fwd_s2;
	logic [WORD_W-1:0] fwd_data_s2;

	logic              on_screen;
	logic [RAM_AW-1:0] in_addr;
	logic              s1_adv;
	logic              s2_load;
	logic              ser_free;

	logic              ram_we;
	logic [RAM_AW-1:0] ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [WORD_W-1:0] ram_rdata;

	logic [WORD_W-1:0] old_word;
	logic [WORD_W-1:0] new_word;
	logic [BYTE_W-1:0] old_byte;
	logic [BYTE_W-1:0] new_byte;
	logic [BYTE_W-1:0] pix_mask;
	logic              lower_half;
	ser_load_t         ser_load;

	// position check and word address of the column pair
	assign on_screen = (int'(pixel_in.pixel_y) < DISPLAY_ROWS) &&
		(int'(pixel_in.pixel_x[X_W-1:3]) < BYTES_PER_ROW);
	assign in_addr = RAM_AW'(int'(pixel_in.pixel_y) * PAIRS_PER_ROW +
		int'(pixel_in.pixel_x[X_W-1:4]));

	// handshake chain: serializer frees s2, s2 frees s1, s1 frees the input
	assign s2_load = valid_s2 && ser_free;
	assign s1_adv = valid_s1 && (!valid_s2 || s2_load);
	assign pixel_in.ready = !clr_busy_q && (!valid_s1 || s1_adv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == RAM_AW'(RAM_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + RAM_AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (pixel_in.valid && pixel_in.ready) begin
				valid_s1 <= on_screen;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				valid_s2 <= 1'b1;
			end else if (s2_load) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pixel_in.valid && pixel_in.ready) begin
			addr_s1 <= in_addr;
			x_s1    <= pixel_in.pixel_x;
			y_s1    <= pixel_in.pixel_y;
			on_s1   <= pixel_in.turn_on;
		end
		if (s1_adv) begin
			addr_s2     <= addr_s1;
			x_s2        <= x_s1;
			y_s2        <= y_s1;
			on_s2       <= on_s1;
			// s2 writes the word that s1 reads in this same cycle
			fwd_s2      <= s2_load && (addr_s2 == addr_s1);
			fwd_data_s2 <= new_word;
		end
	end

	// modify: set or clear one bit in the even or odd byte of the pair
	assign old_word = fwd_s2 ? fwd_data_s2 : ram_rdata;
	assign pix_mask = PIXEL_MASK_MSB >> x_s2[2:0];
	assign old_byte = x_s2[3] ? old_word[BYTE_W-1:0] : old_word[WORD_W-1:BYTE_W];
	assign new_byte = on_s2 ? (old_byte | pix_mask) : (old_byte & ~pix_mask);
	assign new_word = x_s2[3] ? {old_word[WORD_W-1:BYTE_W], new_byte} :
		{new_byte, old_word[BYTE_W-1:0]};

	// clearing pass owns the write port until done; no pixel is in flight then
	assign ram_we = clr_busy_q || s2_load;
	assign ram_waddr = clr_busy_q ? clr_addr_q : addr_s2;
	assign ram_wdata = clr_busy_q ? '0 : new_word;

	lcdsp_ram #(
		.DEPTH (RAM_DEPTH),
		.WIDTH (WORD_W),
		.AW    (RAM_AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (s1_adv),
		.raddr (addr_s1),
		.rdata (ram_rdata)
	);

	// command bytes: lower half rows fold onto rows 0 to 31 with column base 0x88
	assign lower_half = (int'(y_s2) >= HALF_ROWS);
	assign ser_load.row_cmd = ROW_CMD_BASE |
		BYTE_W'(lower_half ? (int'(y_s2) - HALF_ROWS) : int'(y_s2));
	assign ser_load.col_cmd = (lower_half ? COL_CMD_LOWER : COL_CMD_UPPER) |
		BYTE_W'(x_s2[X_W-1:4]);
	assign ser_load.even_byte = new_word[WORD_W-1:BYTE_W];
	assign ser_load.odd_byte = new_word[BYTE_W-1:0];

	lcdsp_ser u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (s2_load),
		.load       (ser_load),
		.free       (ser_free),
		.byte_out   (byte_out)
	);

endmodule

[rtl/lcdsp_checker.sv]
// port-level checker for the pixel write serializer, bound to the top level
module lcdsp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       frame_end,
	input logic       last
);
	import lcdsp_pkg::*;

	// a stalled byte holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
		$stable(frame_end) && $stable(last))
		else $error("stalled byte changed");

	// the final byte of a pixel also closes a transfer
	a_last_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> frame_end)
		else $error("last without frame_end");

	// a transfer following a closed one opens with a sync byte
	a_sync_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && frame_end |=>
		!out_valid || out_byte == SYNC_CMD || out_byte == SYNC_DATA)
		else $error("transfer did not open with sync");

	// a new pixel always starts with the row command sync
	a_pixel_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last |=> !out_valid || out_byte == SYNC_CMD)
		else $error("pixel did not start with command sync");

endmodule

bind lcd_shadow_pixel_write_serializer_unit lcdsp_checker u_lcdsp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (byte_out.valid),
	.out_ready (byte_out.ready),
	.out_byte  (byte_out.out_byte),
	.frame_end (byte_out.frame_end),
	.last      (byte_out.last)
);
